@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in every cycle outside reset.
`define CPF_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define CPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/cpf_pkg.sv @@
// Types and constants of the collider point containment filter.
package cpf_pkg;

    // Widest supported fraction and the quotient width it implies
    localparam int FRAC_MAX = 24;
    localparam int T_W      = FRAC_MAX + 1;
    localparam int WIDE_W   = 70;

    // Shape kinds
    localparam logic [1:0] KIND_BOX     = 2'd0;
    localparam logic [1:0] KIND_SPHERE  = 2'd1;
    localparam logic [1:0] KIND_CAPSULE = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Register indexes
    localparam logic [2:0] CFG_POINT_X    = 3'd0;
    localparam logic [2:0] CFG_POINT_Y    = 3'd1;
    localparam logic [2:0] CFG_POINT_Z    = 3'd2;
    localparam logic [2:0] CFG_LAYER_MASK = 3'd3;
    localparam logic [2:0] CFG_ONLY_TRIG  = 3'd4;
    localparam logic [2:0] CFG_TOLERANCE  = 3'd5;

    typedef logic signed [32:0] crd_t;

    typedef struct packed {
        logic [31:0]        entity_id;
        logic [1:0]         shape_kind;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic [63:0]        rotation;
        logic [30:0]        radius;
        logic [31:0]        layer_mask;
        logic               trig_flag;
    } item_t;

    typedef struct packed {
        logic [31:0] hit_entity;
        logic [1:0]  hit_kind;
    } result_t;

    // Per-item identity and early decisions
    typedef struct packed {
        logic [31:0] entity;
        logic [1:0]  kind;
        logic        pass;
        logic        sphere_hit;
        logic        box_hit;
    } tag_t;

    // Capsule and sphere data leaving the front end
    typedef struct packed {
        tag_t                     tag;
        crd_t [2:0]               rel;
        crd_t [2:0]               seg;
        logic [63:0]              r2;
        logic [WIDE_W-1:0]        len2;
        logic signed [WIDE_W-1:0] dot;
    } cap_t;

    // Box data leaving the front end
    typedef struct packed {
        logic [8:0][62:0] mr;
        logic [2:0][31:0] ext;
    } box_t;

    // Capsule parameter division state
    typedef struct packed {
        tag_t              tag;
        crd_t [2:0]        rel;
        crd_t [2:0]        seg;
        logic [63:0]       r2;
        logic [WIDE_W-1:0] len2;
        logic [WIDE_W-1:0] rem;
        logic [T_W-1:0]    t;
        logic              done;
        logic              full;
    } div_t;

endpackage

@@ design/cpf_front.sv @@
// Front end: differences, quaternion matrix, dot products and sphere test.
module cpf_front import cpf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  item_t              in_data,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [31:0]        query_layer_mask,
    input  logic               trig_only,
    input  logic [15:0]        tolerance,
    output logic               c_valid,
    output cap_t               c_cap,
    output box_t               c_box
);

    localparam logic signed [35:0] ROT_ONE = 36'sh010000000;

    function automatic logic signed [29:0] sat_one(input logic signed [35:0] v);
        logic signed [29:0] r;
        if (v > ROT_ONE)
            r = ROT_ONE[29:0];
        else if (v < -ROT_ONE)
            r = 30'(-ROT_ONE);
        else
            r = v[29:0];
        return r;
    endfunction

    // Stage A registers
    logic               a_valid_reg;
    tag_t               a_tag_reg, a_tag_next;
    logic signed [32:0] a_rel_reg [3];
    logic signed [32:0] a_rel_next [3];
    logic signed [32:0] a_seg_reg [3];
    logic signed [32:0] a_seg_next [3];
    logic [31:0]        a_ext_reg [3];
    logic [31:0]        a_ext_next [3];
    logic signed [31:0] a_qp_reg [9];
    logic signed [31:0] a_qp_next [9];
    logic [31:0]        a_rt_reg, a_rt_next;

    // Stage B registers
    logic               b_valid_reg;
    tag_t               b_tag_reg;
    logic signed [32:0] b_rel_reg [3];
    logic signed [32:0] b_seg_reg [3];
    logic [31:0]        b_ext_reg [3];
    logic signed [29:0] b_m_reg [9];
    logic signed [29:0] b_m_next [9];
    logic signed [65:0] b_sr_reg [3];
    logic signed [65:0] b_sr_next [3];
    logic [65:0]        b_ssq_reg [3];
    logic [65:0]        b_ssq_next [3];
    logic [65:0]        b_rsq_reg [3];
    logic [65:0]        b_rsq_next [3];
    logic [63:0]        b_r2_reg, b_r2_next;

    // Stage C registers
    logic                     c_valid_reg;
    tag_t                     c_tag_reg, c_tag_next;
    logic signed [32:0]       c_rel_reg [3];
    logic signed [32:0]       c_seg_reg [3];
    logic [31:0]              c_ext_reg [3];
    logic signed [62:0]       c_mr_reg [9];
    logic signed [62:0]       c_mr_next [9];
    logic signed [WIDE_W-1:0] c_dot_reg, c_dot_next;
    logic [WIDE_W-1:0]        c_len2_reg, c_len2_next;
    logic [63:0]              c_r2_reg;

    logic signed [31:0] pt [3];
    logic signed [31:0] cen [3];
    logic signed [31:0] sec [3];
    logic signed [15:0] qw, qx, qy, qz;

    assign pt[0]  = point_x;
    assign pt[1]  = point_y;
    assign pt[2]  = point_z;
    assign cen[0] = in_data.center_x;
    assign cen[1] = in_data.center_y;
    assign cen[2] = in_data.center_z;
    assign sec[0] = in_data.second_x;
    assign sec[1] = in_data.second_y;
    assign sec[2] = in_data.second_z;
    assign qw     = $signed(in_data.rotation[15:0]);
    assign qx     = $signed(in_data.rotation[31:16]);
    assign qy     = $signed(in_data.rotation[47:32]);
    assign qz     = $signed(in_data.rotation[63:48]);

    // Filter, differences and quaternion products
    always_comb
    begin
        a_tag_next.entity     = in_data.entity_id;
        a_tag_next.kind       = in_data.shape_kind;
        a_tag_next.pass       = ((in_data.layer_mask & query_layer_mask) != 32'd0)
                                && !(trig_only && !in_data.trig_flag)
                                && (in_data.shape_kind != KIND_NONE);
        a_tag_next.sphere_hit = 1'b0;
        a_tag_next.box_hit    = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            a_rel_next[i] = 33'(pt[i]) - 33'(cen[i]);
            a_seg_next[i] = 33'(sec[i]) - 33'(cen[i]);
            a_ext_next[i] = sec[i][31] ? (~sec[i] + 32'd1) : sec[i];
        end
        a_qp_next[0] = qx * qx;
        a_qp_next[1] = qy * qy;
        a_qp_next[2] = qz * qz;
        a_qp_next[3] = qx * qy;
        a_qp_next[4] = qx * qz;
        a_qp_next[5] = qy * qz;
        a_qp_next[6] = qw * qx;
        a_qp_next[7] = qw * qy;
        a_qp_next[8] = qw * qz;
        a_rt_next = {1'b0, in_data.radius} + {16'd0, tolerance};
    end

    // Matrix entries, segment and distance products
    always_comb
    begin
        logic signed [35:0] q [9];
        logic signed [35:0] raw [9];
        for (int k = 0; k < 9; k++)
            q[k] = 36'(a_qp_reg[k]);
        raw[0] = ROT_ONE - ((q[1] + q[2]) <<< 1);
        raw[1] = (q[3] - q[8]) <<< 1;
        raw[2] = (q[4] + q[7]) <<< 1;
        raw[3] = (q[3] + q[8]) <<< 1;
        raw[4] = ROT_ONE - ((q[0] + q[2]) <<< 1);
        raw[5] = (q[5] - q[6]) <<< 1;
        raw[6] = (q[4] - q[7]) <<< 1;
        raw[7] = (q[5] + q[6]) <<< 1;
        raw[8] = ROT_ONE - ((q[0] + q[1]) <<< 1);
        for (int k = 0; k < 9; k++)
            b_m_next[k] = sat_one(raw[k]);
        for (int i = 0; i < 3; i++)
        begin
            b_sr_next[i]  = a_rel_reg[i] * a_seg_reg[i];
            b_ssq_next[i] = 66'(a_seg_reg[i] * a_seg_reg[i]);
            b_rsq_next[i] = 66'(a_rel_reg[i] * a_rel_reg[i]);
        end
        b_r2_next = a_rt_reg * a_rt_reg;
    end

    // Rotation products, sums and the sphere compare
    always_comb
    begin
        logic [67:0] rsum;
        for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
                c_mr_next[j*3+i] = b_m_reg[j*3+i] * b_rel_reg[j];
        c_dot_next  = WIDE_W'(b_sr_reg[0]) + WIDE_W'(b_sr_reg[1]) + WIDE_W'(b_sr_reg[2]);
        c_len2_next = WIDE_W'(b_ssq_reg[0]) + WIDE_W'(b_ssq_reg[1])
                      + WIDE_W'(b_ssq_reg[2]);
        rsum = 68'(b_rsq_reg[0]) + 68'(b_rsq_reg[1]) + 68'(b_rsq_reg[2]);
        c_tag_next = b_tag_reg;
        c_tag_next.sphere_hit = (rsum <= 68'(b_r2_reg));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_tag_reg  <= a_tag_next;
            a_rel_reg  <= a_rel_next;
            a_seg_reg  <= a_seg_next;
            a_ext_reg  <= a_ext_next;
            a_qp_reg   <= a_qp_next;
            a_rt_reg   <= a_rt_next;
            b_tag_reg  <= a_tag_reg;
            b_rel_reg  <= a_rel_reg;
            b_seg_reg  <= a_seg_reg;
            b_ext_reg  <= a_ext_reg;
            b_m_reg    <= b_m_next;
            b_sr_reg   <= b_sr_next;
            b_ssq_reg  <= b_ssq_next;
            b_rsq_reg  <= b_rsq_next;
            b_r2_reg   <= b_r2_next;
            c_tag_reg  <= c_tag_next;
            c_rel_reg  <= b_rel_reg;
            c_seg_reg  <= b_seg_reg;
            c_ext_reg  <= b_ext_reg;
            c_mr_reg   <= c_mr_next;
            c_dot_reg  <= c_dot_next;
            c_len2_reg <= c_len2_next;
            c_r2_reg   <= b_r2_reg;
        end
    end

    // Drive the outputs
    always_comb
    begin
        c_cap.tag  = c_tag_reg;
        c_cap.r2   = c_r2_reg;
        c_cap.len2 = c_len2_reg;
        c_cap.dot  = c_dot_reg;
        for (int i = 0; i < 3; i++)
        begin
            c_cap.rel[i] = c_rel_reg[i];
            c_cap.seg[i] = c_seg_reg[i];
            c_box.ext[i] = c_ext_reg[i];
        end
        for (int k = 0; k < 9; k++)
            c_box.mr[k] = c_mr_reg[k];
    end

    assign c_valid = c_valid_reg;

endmodule

@@ design/cpf_box.sv @@
// Box test back end: rounding, excess over extents, squared excess compare.
module cpf_box import cpf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        i_valid,
    input  cap_t        i_cap,
    input  box_t        i_box,
    input  logic [15:0] tolerance,
    input  logic [31:0] tol_sq,
    output logic        o_valid,
    output div_t        o_div
);

    localparam logic signed [63:0] RND28 = 64'sd134217728;

    logic               v_reg [4];
    div_t               dd_reg [4];
    div_t               d_init, g_div;

    logic signed [36:0] d_l_reg [3];
    logic signed [36:0] d_l_next [3];
    logic [31:0]        d_ext_reg [3];
    logic [15:0]        e_ex_reg [3];
    logic [15:0]        e_ex_next [3];
    logic               e_fail_reg, e_fail_next;
    logic [31:0]        f_sq_reg [3];
    logic [31:0]        f_sq_next [3];
    logic               f_fail_reg;

    // Round the rotated terms and start the capsule division
    always_comb
    begin
        logic signed [36:0] acc;
        logic signed [63:0] tmp;
        logic               pos, ge;
        for (int i = 0; i < 3; i++)
        begin
            acc = '0;
            for (int j = 0; j < 3; j++)
            begin
                tmp = 64'($signed(i_box.mr[j*3+i])) + RND28;
                acc = acc + 37'(tmp >>> 28);
            end
            d_l_next[i] = acc;
        end
        pos = !i_cap.dot[WIDE_W-1] && (i_cap.dot != '0);
        ge  = $unsigned(i_cap.dot) >= i_cap.len2;
        d_init.tag  = i_cap.tag;
        d_init.rel  = i_cap.rel;
        d_init.seg  = i_cap.seg;
        d_init.r2   = i_cap.r2;
        d_init.len2 = i_cap.len2;
        d_init.rem  = (pos && !ge) ? $unsigned(i_cap.dot) : '0;
        d_init.t    = '0;
        d_init.done = !pos || ge;
        d_init.full = pos && ge;
    end

    // Excess of each rotated coordinate over its extent
    always_comb
    begin
        logic [36:0] al, ex;
        e_fail_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            al = d_l_reg[i][36] ? 37'(-d_l_reg[i]) : 37'(d_l_reg[i]);
            ex = (al > 37'(d_ext_reg[i])) ? (al - 37'(d_ext_reg[i])) : '0;
            if (ex > 37'(tolerance))
                e_fail_next = 1'b1;
            e_ex_next[i] = ex[15:0];
        end
    end

    // Square the excesses
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            f_sq_next[i] = e_ex_reg[i] * e_ex_reg[i];
    end

    // Compare the summed squares with tolerance squared
    always_comb
    begin
        logic [33:0] s;
        s = 34'(f_sq_reg[0]) + 34'(f_sq_reg[1]) + 34'(f_sq_reg[2]);
        g_div = dd_reg[2];
        g_div.tag.box_hit = !f_fail_reg && (s <= 34'(tol_sq));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 4; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= i_valid;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0]  <= d_init;
            dd_reg[1]  <= dd_reg[0];
            dd_reg[2]  <= dd_reg[1];
            dd_reg[3]  <= g_div;
            d_l_reg    <= d_l_next;
            for (int i = 0; i < 3; i++)
                d_ext_reg[i] <= i_box.ext[i];
            e_ex_reg   <= e_ex_next;
            e_fail_reg <= e_fail_next;
            f_sq_reg   <= f_sq_next;
            f_fail_reg <= e_fail_reg;
        end
    end

    assign o_valid = v_reg[3];
    assign o_div   = dd_reg[3];

endmodule

@@ design/cpf_div_step.sv @@
// One restoring division step of the capsule segment parameter.
module cpf_div_step import cpf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic i_valid,
    input  div_t i_div,
    output logic o_valid,
    output div_t o_div
);

    logic valid_reg;
    div_t div_reg, div_next;

    // Shift in one quotient bit unless the parameter is already settled
    always_comb
    begin
        logic [WIDE_W-1:0] r2x;
        div_next = i_div;
        r2x = {i_div.rem[WIDE_W-2:0], 1'b0};
        if (!i_div.done)
        begin
            div_next.t = {i_div.t[T_W-2:0], 1'b0};
            if (r2x >= i_div.len2)
            begin
                div_next.rem  = r2x - i_div.len2;
                div_next.t[0] = 1'b1;
            end
            else
            begin
                div_next.rem = r2x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= i_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            div_reg <= div_next;
    end

    assign o_valid = valid_reg;
    assign o_div   = div_reg;

endmodule

@@ design/cpf_tail.sv @@
// Capsule closest point, distance compare, hit select and output register.
module cpf_tail import cpf_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    i_valid,
    input  div_t    i_div,
    output logic    out_valid,
    output result_t out_data
);

    localparam logic [T_W-1:0]    T_ONE = T_W'(1) << FRACTION_BITS;
    localparam logic signed [59:0] HALF = 60'sd1 <<< (FRACTION_BITS - 1);

    logic               t1_valid_reg, t2_valid_reg, t3_valid_reg;
    tag_t               t1_tag_reg, t2_tag_reg, t3_tag_reg;
    logic [63:0]        t1_r2_reg, t2_r2_reg, t3_r2_reg;
    logic signed [32:0] t1_rel_reg [3];
    logic signed [59:0] t1_prod_reg [3];
    logic signed [59:0] t1_prod_next [3];
    logic signed [34:0] t2_d_reg [3];
    logic signed [34:0] t2_d_next [3];
    logic [67:0]        t3_sq_reg [3];
    logic [67:0]        t3_sq_next [3];
    logic               out_valid_reg, hit;
    result_t            out_data_reg;

    // Scale the segment by the parameter
    always_comb
    begin
        logic [T_W-1:0] tv;
        tv = i_div.full ? T_ONE : i_div.t;
        for (int i = 0; i < 3; i++)
            t1_prod_next[i] = $signed(i_div.seg[i]) * $signed({1'b0, tv});
    end

    // Round to coordinate steps and take the offset to the point
    always_comb
    begin
        logic signed [59:0] q;
        logic signed [60:0] diff;
        for (int i = 0; i < 3; i++)
        begin
            q = (t1_prod_reg[i] + HALF) >>> FRACTION_BITS;
            diff = 61'(t1_rel_reg[i]) - 61'(q);
            t2_d_next[i] = diff[34:0];
        end
    end

    // Square the offsets
    always_comb
    begin
        logic signed [69:0] p;
        for (int i = 0; i < 3; i++)
        begin
            p = t2_d_reg[i] * t2_d_reg[i];
            t3_sq_next[i] = p[67:0];
        end
    end

    // Pick the test of this shape
    always_comb
    begin
        logic [WIDE_W-1:0] s;
        s = WIDE_W'(t3_sq_reg[0]) + WIDE_W'(t3_sq_reg[1]) + WIDE_W'(t3_sq_reg[2]);
        case (t3_tag_reg.kind)
            KIND_BOX:     hit = t3_tag_reg.box_hit;
            KIND_SPHERE:  hit = t3_tag_reg.sphere_hit;
            KIND_CAPSULE: hit = (s <= WIDE_W'(t3_r2_reg));
            default:      hit = 1'b0;
        endcase
        hit = hit && t3_tag_reg.pass;
    end

    // Advance valid bits; drop items that miss
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            t3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_valid_reg  <= i_valid;
            t2_valid_reg  <= t1_valid_reg;
            t3_valid_reg  <= t2_valid_reg;
            out_valid_reg <= t3_valid_reg && hit;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_tag_reg  <= i_div.tag;
            t1_r2_reg   <= i_div.r2;
            for (int i = 0; i < 3; i++)
                t1_rel_reg[i] <= i_div.rel[i];
            t1_prod_reg <= t1_prod_next;
            t2_tag_reg  <= t1_tag_reg;
            t2_r2_reg   <= t1_r2_reg;
            t2_d_reg    <= t2_d_next;
            t3_tag_reg  <= t2_tag_reg;
            t3_r2_reg   <= t2_r2_reg;
            t3_sq_reg   <= t3_sq_next;
            out_data_reg.hit_entity <= t3_tag_reg.entity;
            out_data_reg.hit_kind   <= t3_tag_reg.kind;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ design/collider_point_containment_filter.sv @@
// Top level of the collider point containment filter.
// Throughput: one collider per cycle unless stalled; the capsule divider yields one quotient bit per stage.
// The whole pipeline stalls together while the output register holds a beat that is not taken.
// Reset clears all valid bits and loads the register reset values.
module collider_point_containment_filter import cpf_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [31:0] point_x_reg, point_y_reg, point_z_reg;
    logic [31:0]        layer_mask_reg;
    logic               only_trig_reg;
    logic [15:0]        tol_reg;
    logic [31:0]        tol_sq_reg;
    logic               en;

    logic c_valid, b_valid;
    cap_t c_cap;
    box_t c_box;
    div_t b_div;

    logic dv_valid [FRACTION_BITS+1];
    div_t dv_div [FRACTION_BITS+1];

    // Advance only when the output register is free or its beat is taken
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg    <= '0;
            point_y_reg    <= '0;
            point_z_reg    <= '0;
            layer_mask_reg <= '1;
            only_trig_reg  <= 1'b0;
            tol_reg        <= 16'd1;
            tol_sq_reg     <= 32'd1;
        end
        else
        begin
            tol_sq_reg <= tol_reg * tol_reg;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_POINT_X:    point_x_reg    <= cfg_data;
                    CFG_POINT_Y:    point_y_reg    <= cfg_data;
                    CFG_POINT_Z:    point_z_reg    <= cfg_data;
                    CFG_LAYER_MASK: layer_mask_reg <= cfg_data;
                    CFG_ONLY_TRIG:  only_trig_reg  <= cfg_data[0];
                    CFG_TOLERANCE:  tol_reg        <= cfg_data[15:0];
                    default:        ;
                endcase
            end
        end
    end

    cpf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (in_valid),
        .in_data          (in_data),
        .point_x          (point_x_reg),
        .point_y          (point_y_reg),
        .point_z          (point_z_reg),
        .query_layer_mask (layer_mask_reg),
        .trig_only        (only_trig_reg),
        .tolerance        (tol_reg),
        .c_valid          (c_valid),
        .c_cap            (c_cap),
        .c_box            (c_box)
    );

    cpf_box u_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .i_valid   (c_valid),
        .i_cap     (c_cap),
        .i_box     (c_box),
        .tolerance (tol_reg),
        .tol_sq    (tol_sq_reg),
        .o_valid   (b_valid),
        .o_div     (b_div)
    );

    assign dv_valid[0] = b_valid;
    assign dv_div[0]   = b_div;

    // Divider stages, one quotient bit each
    for (genvar g = 0; g < FRACTION_BITS; g++)
    begin : g_div
        cpf_div_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .i_valid (dv_valid[g]),
            .i_div   (dv_div[g]),
            .o_valid (dv_valid[g+1]),
            .o_div   (dv_div[g+1])
        );
    end

    cpf_tail #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .i_valid   (dv_valid[FRACTION_BITS]),
        .i_div     (dv_div[FRACTION_BITS]),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ design/cpf_checker.sv @@
// Port checker of the collider point containment filter and its bind.
`include "assert_macros.svh"

module cpf_checker import cpf_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data,
    input logic    cfg_ready
);

    // A stalled result beat stays and holds its payload
    `CPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
    `CPF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed")

    // Input is taken whenever the output register can move
    `CPF_ASSERT_NOW(a_in_ready, in_ready == (!out_valid || out_ready), "in_ready mismatch")

    // Register writes are never refused
    `CPF_ASSERT_NOW(a_cfg_ready, cfg_ready, "register write refused")

    // An unknown shape kind never hits
    `CPF_ASSERT_NOW(a_kind, !out_valid || (out_data.hit_kind != KIND_NONE), "unknown kind hit")

endmodule

bind collider_point_containment_filter cpf_checker u_cpf_checker (.*);

@@ dv/collider_point_containment_filter_tb.sv @@
// Testbench for the collider point containment filter: directed and random colliders checked against a local predictor.
module collider_point_containment_filter_tb;
    import cpf_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int PIPE_DEPTH  = 27;
    localparam int DRAIN_WAIT  = PIPE_DEPTH + 13;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 500;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    item_t       in_data;
    logic        out_valid;
    logic        out_ready;
    result_t     out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow copy of the query registers
    logic signed [31:0] q_px, q_py, q_pz;
    logic [31:0]        q_mask;
    logic               q_trig_only;
    logic [15:0]        q_tol;

    result_t hits_pending[$];
    int      err_cnt;
    int      n_items;
    int      n_hits;
    int      n_cfg;
    int      idle_cycles;
    bit      hold_req;

    collider_point_containment_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // Squared length of the gap between the point and a position, against (radius+tol)^2
    function automatic bit reaches(input longint d[3], input logic [30:0] radius);
        logic signed [127:0] dw;
        logic signed [127:0] sum;
        logic signed [127:0] lim;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            dw = d[i];
            sum += dw * dw;
        end
        lim = longint'(radius) + longint'(q_tol);
        return sum <= lim * lim;
    endfunction

    // Rotate the point into the box frame and test the excess over the extents
    function automatic bit inside_box(input longint p[3], input longint c[3], input longint e[3],
                                      input logic [63:0] rot);
        longint qw, qx, qy, qz, one, l, al, ext, ex, tol;
        longint m[3][3];
        longint rel[3];
        longint unsigned acc;
        qw  = longint'($signed(rot[15:0]));
        qx  = longint'($signed(rot[31:16]));
        qy  = longint'($signed(rot[47:32]));
        qz  = longint'($signed(rot[63:48]));
        one = 64'sd1 <<< 28;
        tol = longint'(q_tol);
        acc = 0;
        m[0][0] = one - 2 * (qy * qy + qz * qz);
        m[0][1] = 2 * (qx * qy - qw * qz);
        m[0][2] = 2 * (qx * qz + qw * qy);
        m[1][0] = 2 * (qx * qy + qw * qz);
        m[1][1] = one - 2 * (qx * qx + qz * qz);
        m[1][2] = 2 * (qy * qz - qw * qx);
        m[2][0] = 2 * (qx * qz - qw * qy);
        m[2][1] = 2 * (qy * qz + qw * qx);
        m[2][2] = one - 2 * (qx * qx + qy * qy);
        for (int i = 0; i < 3; i++)
        begin
            rel[i] = p[i] - c[i];
            for (int j = 0; j < 3; j++)
                m[i][j] = m[i][j] > one ? one : (m[i][j] < -one ? -one : m[i][j]);
        end
        for (int i = 0; i < 3; i++)
        begin
            l = 0;
            for (int j = 0; j < 3; j++)
                l += (m[j][i] * rel[j] + (64'sd1 <<< 27)) >>> 28;
            al  = l < 0 ? -l : l;
            ext = e[i] < 0 ? -e[i] : e[i];
            if (al > ext)
            begin
                ex = al - ext;
                if (ex > tol)
                    return 1'b0;
                acc += ex * ex;
            end
        end
        return acc <= tol * tol;
    endfunction

    // Closest point on the segment, parameter clamped and truncated to 16 bits
    function automatic bit inside_capsule(input longint p[3], input longint a[3], input longint b[3],
                                          input logic [30:0] radius);
        longint seg[3], rel[3], d[3];
        logic signed [127:0] sw, rw, dot, len2;
        longint t;
        dot  = 0;
        len2 = 0;
        t    = 0;
        for (int i = 0; i < 3; i++)
        begin
            seg[i] = b[i] - a[i];
            rel[i] = p[i] - a[i];
            sw = seg[i];
            rw = rel[i];
            dot  += sw * rw;
            len2 += sw * sw;
        end
        if (dot > 0)
        begin
            if (dot >= len2)
                t = 64'sd1 <<< 16;
            else
                t = longint'((dot <<< 16) / len2);
        end
        for (int i = 0; i < 3; i++)
            d[i] = p[i] - (a[i] + ((seg[i] * t + 64'sd32768) >>> 16));
        return reaches(d, radius);
    endfunction

    // Decide whether a collider yields a hit under the current registers
    function automatic bit point_inside(input item_t it);
        longint p[3], c[3], s[3];
        if ((it.layer_mask & q_mask) == 32'd0)
            return 1'b0;
        if (q_trig_only && !it.trig_flag)
            return 1'b0;
        p[0] = longint'(q_px);
        p[1] = longint'(q_py);
        p[2] = longint'(q_pz);
        c[0] = longint'($signed(it.center_x));
        c[1] = longint'($signed(it.center_y));
        c[2] = longint'($signed(it.center_z));
        s[0] = longint'($signed(it.second_x));
        s[1] = longint'($signed(it.second_y));
        s[2] = longint'($signed(it.second_z));
        case (it.shape_kind)
            KIND_BOX:     return inside_box(p, c, s, it.rotation);
            KIND_SPHERE:
            begin
                for (int i = 0; i < 3; i++)
                    c[i] = p[i] - c[i];
                return reaches(c, it.radius);
            end
            KIND_CAPSULE: return inside_capsule(p, c, s, it.radius);
            default:      return 1'b0;
        endcase
    endfunction

    // Random gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one collider beat and record its expected hit on acceptance
    task automatic send_item(input item_t it, input bit no_gap = 1'b0);
        int gap;
        result_t r;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_items++;
        if (point_inside(it))
        begin
            r.hit_entity = it.entity_id;
            r.hit_kind   = it.shape_kind;
            hits_pending = {hits_pending, r};
        end
    endtask

    // Drop valid after the last beat of a phase
    task automatic end_items();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every hit has arrived and the pipeline has flushed
    task automatic wait_idle();
        while (hits_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write one register beat; only called while idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            CFG_POINT_X:    q_px        = val;
            CFG_POINT_Y:    q_py        = val;
            CFG_POINT_Z:    q_pz        = val;
            CFG_LAYER_MASK: q_mask      = val;
            CFG_ONLY_TRIG:  q_trig_only = val[0];
            CFG_TOLERANCE:  q_tol       = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] px, py, pz, mask, input bit trig,
                             input logic [15:0] tol);
        write_reg(CFG_POINT_X, px);
        write_reg(CFG_POINT_Y, py);
        write_reg(CFG_POINT_Z, pz);
        write_reg(CFG_LAYER_MASK, mask);
        write_reg(CFG_ONLY_TRIG, {31'd0, trig});
        write_reg(CFG_TOLERANCE, {16'd0, tol});
    endtask

    function automatic logic [31:0] rand_word();
        return $urandom();
    endfunction

    // A near-unit quaternion from a small set of exact rotations
    function automatic logic [63:0] unit_quat();
        logic [15:0] h[4];
        int k;
        k = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
            h[i] = 16'd0;
        case ($urandom_range(0, 2))
            0: h[k] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            1:
            begin
                h[0] = 16'sd11585;
                h[k == 0 ? 1 : k] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                    h[i] = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
            end
        endcase
        return {h[3], h[2], h[1], h[0]};
    endfunction

    // Random collider: mostly placed near the query point, some fully random
    function automatic item_t rand_item();
        item_t       it;
        logic [383:0] raw;
        int          span;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        it = raw[$bits(item_t)-1:0];
        if ($urandom_range(0, 99) < 20)
            return it;
        span = 1 << $urandom_range(4, 22);
        it.shape_kind = 2'($urandom_range(0, 2));
        it.center_x   = q_px + $signed($urandom_range(0, 2 * span)) - span;
        it.center_y   = q_py + $signed($urandom_range(0, 2 * span)) - span;
        it.center_z   = q_pz + $signed($urandom_range(0, 2 * span)) - span;
        it.radius     = 31'($urandom_range(0, 2 * span));
        if (it.shape_kind == KIND_BOX)
        begin
            it.second_x = $signed($urandom_range(0, 2 * span)) - span;
            it.second_y = $signed($urandom_range(0, 2 * span)) - span;
            it.second_z = $signed($urandom_range(0, 2 * span)) - span;
            if ($urandom_range(0, 9) < 8)
                it.rotation = unit_quat();
        end
        else
        begin
            it.second_x = q_px + $signed($urandom_range(0, 2 * span)) - span;
            it.second_y = q_py + $signed($urandom_range(0, 2 * span)) - span;
            it.second_z = q_pz + $signed($urandom_range(0, 2 * span)) - span;
            if ($urandom_range(0, 9) == 0)
                {it.second_x, it.second_y, it.second_z} =
                    {it.center_x, it.center_y, it.center_z};
        end
        if ($urandom_range(0, 9) < 8)
            it.layer_mask = it.layer_mask | q_mask;
        return it;
    endfunction

    function automatic item_t make_item(input logic [1:0] kind, input longint cx, cy, cz,
                                        input longint sx, sy, sz, input logic [63:0] rot,
                                        input logic [30:0] radius);
        item_t it;
        it.entity_id  = $urandom();
        it.shape_kind = kind;
        it.center_x   = 32'(cx);
        it.center_y   = 32'(cy);
        it.center_z   = 32'(cz);
        it.second_x   = 32'(sx);
        it.second_y   = 32'(sy);
        it.second_z   = 32'(sz);
        it.rotation   = rot;
        it.radius     = radius;
        it.layer_mask = 32'hffff_ffff;
        it.trig_flag  = 1'b1;
        return it;
    endfunction

    // Directed colliders under reset registers: extremes and every shape
    task automatic test_reset_defaults();
        item_t it;
        send_item(make_item(KIND_SPHERE, 0, 0, 0, 0, 0, 0, 64'd0, 31'd0));
        send_item(make_item(KIND_SPHERE, 1, 0, 0, 0, 0, 0, 64'd0, 31'd0));
        send_item(make_item(KIND_SPHERE, 2, 0, 0, 0, 0, 0, 64'd0, 31'd0));
        send_item(make_item(KIND_SPHERE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            0, 0, 0, 64'd0, 31'h7fff_ffff));
        send_item(make_item(KIND_SPHERE, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 64'd0, 31'h7fff_ffff));
        send_item(make_item(KIND_BOX, 65536, 0, 0, 65536, 100, 100, 64'h0000_0000_0000_4000,
                            31'd0));
        send_item(make_item(KIND_BOX, 65538, 0, 0, -65536, -100, -100,
                            64'h0000_0000_0000_4000, 31'd0));
        send_item(make_item(KIND_BOX, 65536, 65536, 0, 1000, 1000, 1000,
                            64'h7fff_7fff_7fff_7fff, 31'd0));
        send_item(make_item(KIND_BOX, 300000, 0, 0, 100, 400000, 100,
                            64'h0000_0000_2d41_2d41, 31'd0));
        send_item(make_item(KIND_CAPSULE, 5, 5, 5, 5, 5, 5, 64'd0, 31'd4));
        send_item(make_item(KIND_CAPSULE, -65536, 10, 0, 65536, 10, 0, 64'd0, 31'd9));
        send_item(make_item(KIND_CAPSULE, 100, 0, 0, 200, 0, 0, 64'd0, 31'd99));
        send_item(make_item(KIND_CAPSULE, 32'sh8000_0000, 32'sh8000_0000, 0,
                            32'sh7fff_ffff, 32'sh7fff_ffff, 0, 64'd0, 31'h7fff_ffff));
        send_item(make_item(KIND_NONE, 0, 0, 0, 0, 0, 0, 64'd0, 31'h7fff_ffff));
        it = make_item(KIND_SPHERE, 0, 0, 0, 0, 0, 0, 64'd0, 31'd10);
        it.trig_flag  = 1'b0;
        it.layer_mask = 32'h8000_0000;
        send_item(it);
        end_items();
        wait_idle();
    endtask

    // Layer mask and trigger-only filtering, tolerance extremes
    task automatic test_filters();
        item_t it;
        write_all(0, 0, 0, 32'd0, 1'b0, 16'd0);
        send_item(make_item(KIND_SPHERE, 0, 0, 0, 0, 0, 0, 64'd0, 31'd10));
        end_items();
        wait_idle();
        write_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_00f0, 1'b1, 16'hffff);
        it = make_item(KIND_SPHERE, 32'sh7fff_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                       0, 0, 0, 64'd0, 31'd0);
        it.layer_mask = 32'h0000_0010;
        send_item(it);
        it.trig_flag = 1'b0;
        send_item(it);
        it.trig_flag  = 1'b1;
        it.layer_mask = 32'h0000_000f;
        send_item(it);
        it = make_item(KIND_BOX, 32'sh7fff_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                       0, 0, 0, 64'h0000_0000_0000_4000, 31'd0);
        it.layer_mask = 32'h0000_0080;
        send_item(it);
        end_items();
        wait_idle();
    endtask

    // Random phases, each with fresh registers
    task automatic test_random_phases();
        logic [31:0] px, py, pz, mask;
        for (int ph = 0; ph < 6; ph++)
        begin
            px   = ph == 1 ? 32'h8000_0000 : (ph == 2 ? 32'h7fff_ffff : rand_word());
            py   = ph == 1 ? 32'h8000_0000 : (ph == 2 ? 32'h7fff_ffff : rand_word());
            pz   = ph == 1 ? 32'h8000_0000 : (ph == 2 ? 32'h7fff_ffff : rand_word());
            mask = ph == 3 ? 32'hffff_ffff : rand_word();
            write_all(px, py, pz, mask, ph[0] & ph[1],
                      ph == 4 ? 16'hffff : (ph == 5 ? 16'd0 : 16'($urandom_range(0, 65535))));
            repeat (140) send_item(rand_item());
            end_items();
            wait_idle();
        end
    endtask

    // Hold off the receiver for a long stretch while beats keep coming
    task automatic test_backpressure();
        write_all(0, 0, 0, 32'hffff_ffff, 1'b0, 16'd1);
        hold_req = 1'b1;
        repeat (90) send_item(make_item(KIND_SPHERE, $urandom_range(0, 50), 0, 0,
                                        0, 0, 0, 64'd0, 31'd40), 1'b1);
        end_items();
        wait_idle();
    endtask

    // Receiver readiness: runs of ready with random stalls, plus the long hold
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 50)) @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (pick_gap() > 0)
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    // Compare each result beat with the oldest expected hit
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (hits_pending.size() == 0)
                report_mismatch("unexpected hit entity", out_data.hit_entity, 0);
            else
            begin
                if (out_data.hit_entity !== hits_pending[0].hit_entity)
                    report_mismatch("hit_entity", out_data.hit_entity,
                                    hits_pending[0].hit_entity);
                if (out_data.hit_kind !== hits_pending[0].hit_kind)
                    report_mismatch("hit_kind", out_data.hit_kind, hits_pending[0].hit_kind);
                void'(hits_pending.pop_front());
                n_hits++;
            end
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_POINT_X;
        cfg_data    = '0;
        q_px        = 0;
        q_py        = 0;
        q_pz        = 0;
        q_mask      = 32'hffff_ffff;
        q_trig_only = 1'b0;
        q_tol       = 16'd1;
        err_cnt     = 0;
        n_items     = 0;
        n_hits      = 0;
        n_cfg       = 0;
        idle_cycles = 0;
        hold_req    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_filters();
        test_random_phases();
        test_backpressure();
        if (hits_pending.size() != 0)
            report_mismatch("hits never delivered", hits_pending.size(), 0);
        $display("Covered %0d colliders (box, sphere, capsule, unknown kind), %0d hits, %0d",
                 n_items, n_hits, n_cfg);
        $display("register writes, layer and trigger filtering and a long output stall.");
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/cpf_pkg.sv
design/cpf_front.sv
design/cpf_box.sv
design/cpf_div_step.sv
design/cpf_tail.sv
design/collider_point_containment_filter.sv
design/cpf_checker.sv
dv/collider_point_containment_filter_tb.sv
